@@ src/bss_pkg.sv @@
// ----------------------------------------------------------------------------
// Bounded substring search: shared definitions
// Result codes, the control group handed to every window cell, and the
// ASCII case-folding helper used by both the cells and the top level.
// ----------------------------------------------------------------------------
package bss_pkg;

   localparam int unsigned BYTE_W = 8;

   // Result codes carried in the status field of a result beat.
   typedef enum logic [1:0] {
      STATUS_SEARCHING = 2'd0,
      STATUS_FOUND     = 2'd1,
      STATUS_NOT_FOUND = 2'd2,
      STATUS_IGNORED   = 2'd3
   } status_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_NEEDLE_BYTES  = 3'd0;
   localparam logic [2:0] REG_NEEDLE_LENGTH = 3'd1;
   localparam logic [2:0] REG_CASE_FOLD     = 3'd2;
   localparam logic [2:0] REG_LIMIT_ENABLE  = 3'd3;
   localparam logic [2:0] REG_SEARCH_LIMIT  = 3'd4;

   // Control group driven by the top level into every window cell. The shift
   // enable travels on its own, as it depends on the cells' compare results.
   typedef struct packed {
      logic fresh;    // this beat starts a new haystack: window reads as zeros
      logic fold_en;  // compare after ASCII lower-casing
   } bss_ctl_type;

   // Lower-cases ASCII A-Z when enabled; every other code passes unchanged.
   function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] c,
                                                   input logic en);
      if (en && (c >= 8'h41) && (c <= 8'h5A)) begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage

@@ src/bss_cell.sv @@
// ----------------------------------------------------------------------------
// Bounded substring search: window cell
// Holds one earlier haystack byte, passes it to its neighbour as the window
// slides, and compares it with the needle byte that falls on its position.
// ----------------------------------------------------------------------------
module bss_cell #(
   parameter int unsigned NEEDLE_MAX = 8,
   parameter int unsigned POS        = 0,
   localparam int unsigned LEN_W     = $clog2(NEEDLE_MAX + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bss_pkg::bss_ctl_type          ctl,
   input  logic                          shift,
   input  logic [bss_pkg::BYTE_W-1:0]    byte_in,
   output logic [bss_pkg::BYTE_W-1:0]    byte_out,
   input  logic [NEEDLE_MAX*bss_pkg::BYTE_W-1:0] needle,
   input  logic [LEN_W-1:0]              eff_len,
   output logic                          hit
);

   logic [bss_pkg::BYTE_W-1:0] byte_ff;
   logic [bss_pkg::BYTE_W-1:0] byte_in_eff;
   logic [bss_pkg::BYTE_W-1:0] needle_sel;
   logic                       takes_part;

   // A new haystack sees an all-zero window.
   assign byte_in_eff = ctl.fresh ? '0 : byte_ff;
   assign byte_out    = byte_in_eff;

   // This cell holds the byte POS+1 places back, which lines up with needle
   // byte eff_len-2-POS when the needle is long enough to reach it.
   always_comb begin
      needle_sel = '0;
      takes_part = 1'b0;
      for (int jj = 0; jj < NEEDLE_MAX; jj++) begin
         if (int'(eff_len) == jj + int'(POS) + 2) begin
            needle_sel = needle[jj*bss_pkg::BYTE_W +: bss_pkg::BYTE_W];
            takes_part = 1'b1;
         end
      end
      hit = !takes_part ||
            (bss_pkg::fold_byte(byte_in_eff, ctl.fold_en) ==
             bss_pkg::fold_byte(needle_sel, ctl.fold_en));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else if (shift) begin
         byte_ff <= byte_in;
      end
   end

endmodule

@@ src/bounded_substring_search_unit.sv @@
// ----------------------------------------------------------------------------
// Bounded substring search unit
// Streams haystack bytes past a programmable needle of up to eight bytes and
// reports, for every byte, whether the needle has been found, ruled out or
// is still being searched for.
// ----------------------------------------------------------------------------
// Each haystack byte is one beat on the req_ channel and produces exactly one
// result beat on the rsp_ channel. The unit takes one byte per clock cycle
// while its output is not stalled: the whole needle is compared in the
// cycle the byte arrives, against a row of window cells holding the
// previous NEEDLE_MAX-1 bytes, and the verdict is held in an output register.
// A new byte is accepted whenever that register is empty or its result is
// taken in the same cycle, so a consumer that stalls holds the input back
// for as long as it stalls. A byte with req_tuser set starts a new haystack
// at offset zero; after a match or a miss has been reported the remaining
// bytes of that haystack are answered with the ignored code until the next
// haystack starts. An empty needle is reported as found at offset zero on
// the first byte. A match counts only if it ends before a zero byte and,
// with the limit enabled, before the byte at offset search_limit.
// The user must write configuration through the csr_ port only while no bytes
// are in flight; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module bounded_substring_search_unit #(
   parameter int unsigned NEEDLE_MAX = 8,
   parameter int unsigned INDEX_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   // Haystack input.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] hay_byte
   input  logic        req_tuser,   // [0] first_byte

   // Search results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] status, [17:2] match_start, rest zero

   // Configuration registers.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned LEN_W  = $clog2(NEEDLE_MAX + 1);
   localparam int unsigned IDXP_W = INDEX_BITS + 1;
   localparam int unsigned CMP_W  = (INDEX_BITS > 16) ? INDEX_BITS : 16;
   localparam int unsigned NDL_W  = NEEDLE_MAX * bss_pkg::BYTE_W;

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [63:0] needle_bytes_ff;
   logic [3:0]  needle_length_ff;
   logic        case_fold_ff;
   logic        limit_enable_ff;
   logic [15:0] search_limit_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         needle_bytes_ff  <= '0;
         needle_length_ff <= '0;
         case_fold_ff     <= 1'b0;
         limit_enable_ff  <= 1'b1;
         search_limit_ff  <= 16'hFFFF;
      end else if (csr_write) begin
         unique case (csr_index)
            bss_pkg::REG_NEEDLE_BYTES:  needle_bytes_ff  <= csr_pwdata;
            bss_pkg::REG_NEEDLE_LENGTH: needle_length_ff <= csr_pwdata[3:0];
            bss_pkg::REG_CASE_FOLD:     case_fold_ff     <= csr_pwdata[0];
            bss_pkg::REG_LIMIT_ENABLE:  limit_enable_ff  <= csr_pwdata[0];
            bss_pkg::REG_SEARCH_LIMIT:  search_limit_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         bss_pkg::REG_NEEDLE_BYTES:  csr_prdata = needle_bytes_ff;
         bss_pkg::REG_NEEDLE_LENGTH: csr_prdata = 64'(needle_length_ff);
         bss_pkg::REG_CASE_FOLD:     csr_prdata = 64'(case_fold_ff);
         bss_pkg::REG_LIMIT_ENABLE:  csr_prdata = 64'(limit_enable_ff);
         bss_pkg::REG_SEARCH_LIMIT:  csr_prdata = 64'(search_limit_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Effective needle length: the programmed length, capped at NEEDLE_MAX,
   // and cut short at the first zero byte as a C string would be.
   // ------------------------------------------------------------------------
   logic [NDL_W-1:0] needle;
   logic [LEN_W-1:0] len_cap;
   logic [LEN_W-1:0] eff_len;

   assign needle = needle_bytes_ff[NDL_W-1:0];

   always_comb begin
      if (32'(needle_length_ff) > NEEDLE_MAX) begin
         len_cap = LEN_W'(NEEDLE_MAX);
      end else begin
         len_cap = LEN_W'(needle_length_ff);
      end
      eff_len = len_cap;
      // Walk downwards so that the lowest zero byte has the last word.
      for (int k = NEEDLE_MAX - 1; k >= 0; k--) begin
         if ((k < int'(len_cap)) &&
             (needle[k*bss_pkg::BYTE_W +: bss_pkg::BYTE_W] == '0)) begin
            eff_len = LEN_W'(k);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Per-haystack state. A beat that starts a new haystack sees index zero,
   // an undecided search and an all-zero window, whatever was held before.
   // ------------------------------------------------------------------------
   logic [INDEX_BITS-1:0] byte_index_ff, byte_index_in;
   logic                  decided_ff, decided_in;
   logic                  req_accept;
   logic                  fresh;
   logic [INDEX_BITS-1:0] index_eff;
   logic                  decided_eff;
   logic [7:0]            hay_byte;

   assign hay_byte    = req_tdata;
   assign fresh       = req_tuser;
   assign index_eff   = fresh ? '0 : byte_index_ff;
   assign decided_eff = fresh ? 1'b0 : decided_ff;

   // ------------------------------------------------------------------------
   // Window cells. hits[0] is the incoming byte against the last needle
   // byte; hits[k+1] comes from the cell holding the byte k+1 places back.
   // ------------------------------------------------------------------------
   bss_pkg::bss_ctl_type       cell_ctl;
   logic                       cell_shift;
   logic [bss_pkg::BYTE_W-1:0] chain [NEEDLE_MAX];
   logic [NEEDLE_MAX-1:0]      hits;
   logic [bss_pkg::BYTE_W-1:0] last_needle;
   logic                       searching;

   assign chain[0] = hay_byte;

   always_comb begin
      cell_ctl.fresh   = fresh;
      cell_ctl.fold_en = case_fold_ff;
   end

   // The window only moves on while the search is still open.
   assign cell_shift = req_accept && searching;

   always_comb begin
      last_needle = '0;
      for (int jj = 0; jj < NEEDLE_MAX; jj++) begin
         if (int'(eff_len) == jj + 1) begin
            last_needle = needle[jj*bss_pkg::BYTE_W +: bss_pkg::BYTE_W];
         end
      end
      hits[0] = (bss_pkg::fold_byte(hay_byte, case_fold_ff) ==
                 bss_pkg::fold_byte(last_needle, case_fold_ff));
   end

   for (genvar g = 0; g < NEEDLE_MAX - 1; g++) begin : g_cell
      bss_cell #(
         .NEEDLE_MAX (NEEDLE_MAX),
         .POS        (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (cell_ctl),
         .shift    (cell_shift),
         .byte_in  (chain[g]),
         .byte_out (chain[g+1]),
         .needle   (needle),
         .eff_len  (eff_len),
         .hit      (hits[g+1])
      );
   end

   // ------------------------------------------------------------------------
   // Verdict for the current beat.
   // ------------------------------------------------------------------------
   logic [IDXP_W-1:0]   index_p1;
   logic [IDXP_W-1:0]   start_full;
   logic                long_enough;
   logic                over_limit;
   bss_pkg::status_type status_in;
   logic [15:0]         match_start_in;

   assign index_p1    = IDXP_W'(index_eff) + IDXP_W'(1);
   assign long_enough = index_p1 >= IDXP_W'(eff_len);
   assign start_full  = index_p1 - IDXP_W'(eff_len);
   assign over_limit  = limit_enable_ff && (CMP_W'(index_eff) >= CMP_W'(search_limit_ff));

   always_comb begin
      status_in      = bss_pkg::STATUS_SEARCHING;
      match_start_in = '0;
      priority if (decided_eff) begin
         status_in = bss_pkg::STATUS_IGNORED;
      end else if (eff_len == '0) begin
         status_in = bss_pkg::STATUS_FOUND;
      end else if (over_limit || (hay_byte == '0)) begin
         status_in = bss_pkg::STATUS_NOT_FOUND;
      end else if (long_enough && (&hits)) begin
         status_in      = bss_pkg::STATUS_FOUND;
         match_start_in = 16'(start_full);
      end else begin
         status_in = bss_pkg::STATUS_SEARCHING;
      end
   end

   assign searching  = (status_in == bss_pkg::STATUS_SEARCHING);
   assign decided_in = !searching;

   // The index stops at its all-ones value rather than wrapping.
   assign byte_index_in = (&index_eff) ? index_eff : index_eff + INDEX_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         decided_ff    <= 1'b0;
      end else if (req_accept) begin
         decided_ff <= decided_in;
         if (searching) begin
            byte_index_ff <= byte_index_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output register. A new byte is taken whenever the register is empty or
   // its result is leaving in the same cycle.
   // ------------------------------------------------------------------------
   logic                rsp_valid_ff;
   bss_pkg::status_type status_ff;
   logic [15:0]         match_start_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff      <= status_in;
         match_start_ff <= match_start_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, match_start_ff, status_ff};

endmodule

@@ bench/bounded_substring_search_checker.sv @@
// ----------------------------------------------------------------------------
// Bounded substring search checker
// Watches the haystack, result and register channels of the search unit. It
// keeps its own copy of the registers and of the search state, works out the
// verdict for every haystack beat and compares each result beat with it.
// ----------------------------------------------------------------------------
module bounded_substring_search_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] hay_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [1:0] status, [17:2] match_start, rest zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      bss_pkg::status_type status;
      logic [15:0]         start;
   } verdict_type;

   verdict_type awaited_verdicts[$];

   logic [63:0] needle      = '0;
   logic [3:0]  needle_len  = '0;
   logic        fold_on     = 1'b0;
   logic        limit_on    = 1'b1;
   logic [15:0] limit       = 16'hFFFF;
   logic [7:0]  window [7];
   logic [15:0] offset      = '0;
   logic        decided     = 1'b0;
   int          mismatches  = 0;

   initial begin
      error_count   = 0;
      pending_count = 0;
      foreach (window[k]) window[k] = 8'h00;
   end

   function automatic logic [7:0] lower_case(input logic [7:0] c);
      if (fold_on && (c >= 8'h41) && (c <= 8'h5A)) begin
         return c | 8'h20;
      end
      return c;
   endfunction

   // Length of the needle as searched: capped at eight bytes and cut at the
   // first zero byte, as a C string would be.
   function automatic int needle_span();
      int span;
      int k;
      span = (needle_len > 4'd8) ? 8 : int'(needle_len);
      for (k = 0; k < span; k++) begin
         if (needle[8*k +: 8] == 8'h00) begin
            return k;
         end
      end
      return span;
   endfunction

   function automatic void start_haystack();
      foreach (window[k]) window[k] = 8'h00;
      offset  = '0;
      decided = 1'b0;
   endfunction

   function automatic verdict_type scan_byte(input logic [7:0] b, input logic first);
      verdict_type v;
      int          span;
      int          j;
      logic        hit;
      logic [7:0]  hb;
      v.status = bss_pkg::STATUS_SEARCHING;
      v.start  = '0;
      if (first) begin
         start_haystack();
      end
      if (decided) begin
         v.status = bss_pkg::STATUS_IGNORED;
         return v;
      end
      span = needle_span();
      if (span == 0) begin
         v.status = bss_pkg::STATUS_FOUND;
         decided  = 1'b1;
         return v;
      end
      if ((limit_on && (offset >= limit)) || (b == 8'h00)) begin
         v.status = bss_pkg::STATUS_NOT_FOUND;
         decided  = 1'b1;
         return v;
      end
      hit = (int'(offset) + 1 >= span);
      for (j = 0; j < span; j++) begin
         hb = (j == span - 1) ? b : window[span - 2 - j];
         if (lower_case(hb) != lower_case(needle[8*j +: 8])) begin
            hit = 1'b0;
         end
      end
      if (hit) begin
         v.status = bss_pkg::STATUS_FOUND;
         v.start  = offset + 16'd1 - 16'(span);
         decided  = 1'b1;
         return v;
      end
      for (j = 6; j > 0; j--) begin
         window[j] = window[j - 1];
      end
      window[0] = b;
      if (offset != 16'hFFFF) begin
         offset++;
      end
      return v;
   endfunction

   task automatic report_mismatch(input string text);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] result mismatch: %s", $time, text);
      end
   endtask

   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         needle     = '0;
         needle_len = '0;
         fold_on    = 1'b0;
         limit_on   = 1'b1;
         limit      = 16'hFFFF;
         start_haystack();
         awaited_verdicts.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[5:3])
               bss_pkg::REG_NEEDLE_BYTES:  needle     = csr_pwdata;
               bss_pkg::REG_NEEDLE_LENGTH: needle_len = csr_pwdata[3:0];
               bss_pkg::REG_CASE_FOLD:     fold_on    = csr_pwdata[0];
               bss_pkg::REG_LIMIT_ENABLE:  limit_on   = csr_pwdata[0];
               bss_pkg::REG_SEARCH_LIMIT:  limit      = csr_pwdata[15:0];
               default: ;
            endcase
         end
         // Results leave before the beat taken at the same edge can have one.
         if (rsp_tvalid && rsp_tready) begin
            got.status = bss_pkg::status_type'(rsp_tdata[1:0]);
            got.start  = rsp_tdata[17:2];
            if (awaited_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, status %0d start %0d",
                                         got.status, got.start));
            end else begin
               want = awaited_verdicts.pop_front();
               if ((got.status != want.status) || (got.start != want.start)) begin
                  report_mismatch($sformatf("status %0d start %0d, expected %0d and %0d",
                                            got.status, got.start, want.status, want.start));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_verdicts.push_back(scan_byte(req_tdata, req_tuser));
         end
      end
      error_count   <= mismatches;
      pending_count <= awaited_verdicts.size();
   end

endmodule

@@ bench/bounded_substring_search_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Bounded substring search unit testbench
// Drives haystack bytes and register writes into the search unit, first in a
// short directed run over the corner cases and then in random haystacks under
// many register settings, while a checker beside the unit predicts and checks
// every result beat.
// ----------------------------------------------------------------------------
module bounded_substring_search_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [7:0]  req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tready  = 1'b0;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [5:0]  csr_paddr   = '0;
   logic [63:0] csr_pwdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [23:0] rsp_tdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int error_count;
   int pending_count;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int send_idle_pct = 26;
   int recv_idle_pct = 51;

   // Copy of the programmed needle, so that haystacks can be built to contain it.
   logic [63:0] needle_copy     = '0;
   logic [3:0]  needle_len_copy = '0;

   bounded_substring_search_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   bounded_substring_search_checker match_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver stalls at random; with the percentage at zero it never does.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // A hard stop well beyond the slowest correct run, with all of its beats
   // and register writes under the heaviest stalls.
   initial begin
      #200_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Offers one haystack beat and returns at the edge that takes it. A gap of
   // idle cycles may come first; tvalid is only lowered for a gap,
   // so back-to-back beats keep it high.
   task automatic send_byte(input logic [7:0] b, input logic first);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering beats and waits until every result beat has been taken.
   // The first edge lets the checker count the beat accepted just now.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // One register write: a setup phase, then the access phase until pready.
   task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {index, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Rewrites every register once the unit has gone quiet. The unit holds each
   // answer only in its output register, so no work is left once all results are in.
   task automatic program_search(input logic [63:0] needle, input logic [3:0] len,
                                 input logic fold, input logic limit_on,
                                 input logic [15:0] limit);
      wait_for_results();
      write_reg(bss_pkg::REG_NEEDLE_BYTES, needle);
      write_reg(bss_pkg::REG_NEEDLE_LENGTH, {60'd0, len});
      write_reg(bss_pkg::REG_CASE_FOLD, {63'd0, fold});
      write_reg(bss_pkg::REG_LIMIT_ENABLE, {63'd0, limit_on});
      write_reg(bss_pkg::REG_SEARCH_LIMIT, {48'd0, limit});
      needle_copy     = needle;
      needle_len_copy = len;
   endtask

   // Letters around the edges of the folded range, so that folding matters.
   function automatic logic [7:0] pick_letter();
      case ($urandom_range(9))
         0:       return 8'h61;   // a
         1:       return 8'h41;   // A
         2:       return 8'h62;   // b
         3:       return 8'h42;   // B
         4:       return 8'h7A;   // z
         5:       return 8'h5A;   // Z
         6:       return 8'h40;   // just below A
         7:       return 8'h5B;   // just above Z
         8:       return 8'h60;   // just below a
         default: return 8'h7B;   // just above z
      endcase
   endfunction

   // A random register setting. Short needles dominate so that matches are
   // frequent; zero bytes inside the needle, lengths beyond eight and the
   // limit extremes all turn up regularly.
   task automatic program_random_search();
      logic [63:0] needle;
      logic [3:0]  len;
      logic [15:0] limit;
      int          r;
      int          k;
      for (k = 0; k < 8; k++) begin
         r = $urandom_range(99);
         if (r < 75) begin
            needle[8*k +: 8] = pick_letter();
         end else if (r < 80) begin
            needle[8*k +: 8] = 8'h00;
         end else begin
            needle[8*k +: 8] = 8'($urandom_range(255));
         end
      end
      r = $urandom_range(99);
      if (r < 8) begin
         len = 4'd0;
      end else if (r < 70) begin
         len = 4'($urandom_range(1, 4));
      end else if (r < 85) begin
         len = 4'($urandom_range(5, 8));
      end else begin
         len = 4'($urandom_range(9, 15));
      end
      r = $urandom_range(99);
      if (r < 10) begin
         limit = 16'd0;
      end else if (r < 20) begin
         limit = 16'hFFFF;
      end else if (r < 80) begin
         limit = 16'($urandom_range(1, 16));
      end else begin
         limit = 16'($urandom_range(65535));
      end
      program_search(needle, len, 1'($urandom_range(1)), ($urandom_range(3) != 0), limit);
   endtask

   // Sends one short haystack, mostly letters with the odd random or zero
   // byte, and in half of them a copy of the needle with some letters in the
   // other case. Now and then the first beat lacks the first-byte flag, or a
   // beat in the middle carries it, so that haystacks run into each other.
   task automatic send_haystack(output int len);
      logic [7:0] hay [16];
      logic [7:0] c;
      int         span;
      int         at;
      int         k;
      int         r;
      len = $urandom_range(1, 16);
      for (k = 0; k < len; k++) begin
         r = $urandom_range(99);
         if (r < 3) begin
            hay[k] = 8'h00;
         end else if (r < 15) begin
            hay[k] = 8'($urandom_range(1, 255));
         end else begin
            hay[k] = pick_letter();
         end
      end
      span = (needle_len_copy > 4'd8) ? 8 : int'(needle_len_copy);
      if ((span > 0) && (span <= len) && ($urandom_range(1) == 1)) begin
         at = $urandom_range(0, len - span);
         for (k = 0; k < span; k++) begin
            c = needle_copy[8*k +: 8];
            if (((c | 8'h20) >= 8'h61) && ((c | 8'h20) <= 8'h7A) &&
                ($urandom_range(3) == 0)) begin
               c = c ^ 8'h20;
            end
            hay[at + k] = c;
         end
      end
      for (k = 0; k < len; k++) begin
         send_byte(hay[k], (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0));
      end
   endtask

   initial begin
      int phase;
      int setting;
      int sent;
      int n;
      int k;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Straight out of reset the needle is empty: the first beat is found at
      // offset zero even without the first-byte flag, and the next is ignored.
      send_byte(8'h55, 1'b0);
      send_byte(8'h00, 1'b0);

      // Needle "aBc" with folding and a limit of four bytes.
      program_search(64'h0000_0000_0063_4261, 4'd3, 1'b1, 1'b1, 16'd4);
      // Found at offset one in mixed case, then a beat after the decision.
      send_byte(8'h78, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h43, 1'b0);
      send_byte(8'hFF, 1'b0);
      // A zero byte ends the haystack before the needle completes.
      send_byte(8'h61, 1'b1);
      send_byte(8'h62, 1'b0);
      send_byte(8'h00, 1'b0);
      // The byte at offset four lies beyond the limit.
      send_byte(8'h71, 1'b1);
      send_byte(8'h72, 1'b0);
      send_byte(8'h73, 1'b0);
      send_byte(8'h74, 1'b0);
      send_byte(8'h75, 1'b0);

      // An over-long length acts as eight; exact compare of extreme byte
      // values with folding and the limit both off.
      program_search(64'h01FF_7F80_415A_617A, 4'd15, 1'b0, 1'b0, 16'd0);
      send_byte(8'h33, 1'b1);
      for (k = 0; k < 8; k++) begin
         send_byte(needle_copy[8*k +: 8], 1'b0);
      end

      // Random haystacks: the sender idles less than the receiver, then the
      // other way round, then neither holds back.
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 26;
               recv_idle_pct = 51;
            end
            1: begin
               send_idle_pct = 51;
               recv_idle_pct = 26;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (setting = 0; setting < 10; setting++) begin
            program_random_search();
            sent = 0;
            while (sent < 45) begin
               send_haystack(n);
               sent += n;
            end
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
